// ===== hdl/profile_rate_pacer_defines.svh =====
// Assertion macros for the profile rate pacer.
// Used by profile_rate_pacer.sv; expects signals clock and reset in scope.
`ifndef PROFILE_RATE_PACER_DEFINES_SVH
`define PROFILE_RATE_PACER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define PRP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hdl/prp_pkg.sv =====
// Shared types and constants of the profile rate pacer.
// No dependencies; used by profile_rate_pacer.sv.
package prp_pkg;

   localparam int DEF_PROFILE_DEPTH = 256;
   localparam int DEF_MAX_BATCH     = 64;
   localparam int DEF_TIME_BITS     = 48;

   localparam int RATE_W       = 27;
   localparam int FIELD_TIME_W = 48;
   localparam int BATCH_W      = 7;
   localparam int COUNT_W      = 9;

   localparam longint unsigned NS_PER_SEC = 64'd1_000_000_000;

   localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

   // item modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_PACE  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_PACING_RATE   = 2'd0;
   localparam logic [1:0] REG_USE_PROFILE   = 2'd1;
   localparam logic [1:0] REG_BATCH_SIZE    = 2'd2;
   localparam logic [1:0] REG_PROFILE_COUNT = 2'd3;

   typedef struct packed {
      logic [1:0]              mode;
      logic [7:0]              point_index;
      logic [FIELD_TIME_W-1:0] point_time;
      logic [RATE_W-1:0]       point_rate;
      logic [FIELD_TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic                    go;
      logic [FIELD_TIME_W-1:0] deadline;
      logic [RATE_W-1:0]       applied_rate;
   } rsp_type;

endpackage

// ===== hdl/profile_rate_pacer.sv =====
// Batch pacer: start / profile load / pace request items, one result each.
// Top level of the block; depends on prp_pkg and profile_rate_pacer_defines.svh.
//
// Usage: req_valid/req_stall carry items (start, load profile point, pace
// request), rsp_valid/rsp_stall carry one result per item. An APB port
// sets pacing_rate, use_profile, batch_size and profile_count; the user is
// to write them only while idle, and the block itself does not enforce it.
// One item is in work at a time; req_stall is high while it is. Start,
// load, refused or unpaced requests go straight from idle to the output
// state. A paced request at a fixed rate finds the batch time with a
// one-bit-per-cycle restoring divider over NW bits, the width of
// MAX_BATCH * 1e9 (36 at the default). With a profile, a table search
// first reads points, one memory read each (up to PROFILE_DEPTH points), and
// interpolation runs a serial multiply-divide. Profile memories are never
// cleared. The finished result sits in an output register; the next item
// is taken while it waits on rsp_stall, but a further result waits in the
// block. Reset clears registers, start time and deadline to their defaults.
`include "profile_rate_pacer_defines.svh"

module profile_rate_pacer #(
   parameter int PROFILE_DEPTH = prp_pkg::DEF_PROFILE_DEPTH,
   parameter int MAX_BATCH     = prp_pkg::DEF_MAX_BATCH,
   parameter int TIME_BITS     = prp_pkg::DEF_TIME_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  prp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output prp_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int T    = TIME_BITS;
   localparam int RW   = prp_pkg::RATE_W;
   localparam int AW   = $clog2(PROFILE_DEPTH);
   localparam int BW   = $clog2(MAX_BATCH + 1);
   localparam longint unsigned NUM_MAX = longint'(MAX_BATCH) * prp_pkg::NS_PER_SEC;
   localparam int NW   = $clog2(NUM_MAX + 64'd1);
   localparam int W    = ((NW > T) ? NW : T) + 1;
   localparam int DCW  = $clog2(NW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_CHECK, S_MD, S_PREP, S_DIV, S_ADD, S_END, S_OUT
   } state_type;

   state_type state_ff;

   logic [RW-1:0]               pacing_rate_ff;
   logic                        use_profile_ff;
   logic [prp_pkg::BATCH_W-1:0] batch_ff;
   logic [prp_pkg::COUNT_W-1:0] count_ff;

   logic [T-1:0] start_ff, deadline_ff, now_ff, e_ff;

   logic [T-1:0]  mem_t [PROFILE_DEPTH];
   logic [RW-1:0] mem_r [PROFILE_DEPTH];
   logic [T-1:0]  t_rd_ff;
   logic [RW-1:0] r_rd_ff;
   logic [AW-1:0] idx_ff, last_ff;
   logic [T-1:0]  prev_t_ff;
   logic [RW-1:0] prev_r_ff;

   logic [T-1:0]  md_num_ff, md_rem_ff;
   logic [T:0]    md_div_ff;
   logic [RW-1:0] md_diff_ff, md_q_ff, md_r0_ff;
   logic          md_neg_ff;
   logic [4:0]    md_cnt_ff;

   logic [RW-1:0]  rate_ff;
   logic [NW-1:0]  dv_num_ff, dv_q_ff;
   logic [RW-1:0]  dv_rem_ff;
   logic [DCW-1:0] dv_cnt_ff;
   logic [W-1:0]   sum_ff;

   logic          res_go_ff;
   logic [RW-1:0] res_rate_ff;
   logic             rsp_valid_ff;
   prp_pkg::rsp_type rsp_data_ff;

   logic req_xfer, cfg_wr, wr_en;
   logic [T-1:0]  now_in, ptime_in;
   logic [AW-1:0] wr_addr_in, last_in;

   logic [T+1:0]  md_s_in, md_d1_in, md_d2_in;
   logic [T-1:0]  md_rem_in;
   logic [RW-1:0] md_q_in;

   logic [RW:0]   dv_s_in;
   logic          dv_ge_in;
   logic [RW-1:0] dv_rem_in;

   logic [BW-1:0] batch_in;
   logic [T-1:0]  nd_in;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;

   assign now_in     = T'(req_data.now_time);
   assign ptime_in   = T'(req_data.point_time);
   assign wr_addr_in = AW'(req_data.point_index);
   assign wr_en      = req_xfer && (req_data.mode == prp_pkg::MODE_LOAD) &&
                       (32'(req_data.point_index) < 32'(PROFILE_DEPTH));

   // last table entry to search, count clamped to 1..PROFILE_DEPTH
   always_comb begin
      if (32'(count_ff) > 32'(PROFILE_DEPTH)) begin
         last_in = AW'(PROFILE_DEPTH - 1);
      end else if (count_ff == '0) begin
         last_in = '0;
      end else begin
         last_in = AW'(count_ff - 9'd1);
      end
   end

   // one step of floor(num * diff / div), one quotient digit of at most 2 per bit
   always_comb begin
      md_s_in  = {1'b0, md_rem_ff, 1'b0} + (md_diff_ff[RW-1] ? {2'b0, md_num_ff} : '0);
      md_d1_in = {1'b0, md_div_ff};
      md_d2_in = {md_div_ff, 1'b0};
      priority if (md_s_in >= md_d2_in) begin
         md_rem_in = T'(md_s_in - md_d2_in);
         md_q_in   = {md_q_ff[RW-2:0], 1'b0} + RW'(2);
      end else if (md_s_in >= md_d1_in) begin
         md_rem_in = T'(md_s_in - md_d1_in);
         md_q_in   = {md_q_ff[RW-2:0], 1'b0} + RW'(1);
      end else begin
         md_rem_in = T'(md_s_in);
         md_q_in   = {md_q_ff[RW-2:0], 1'b0};
      end
   end

   // restoring divide step of batch * 1e9 by rate
   always_comb begin
      dv_s_in   = {dv_rem_ff, dv_num_ff[NW-1]};
      dv_ge_in  = dv_s_in >= {1'b0, rate_ff};
      dv_rem_in = dv_ge_in ? RW'(dv_s_in - {1'b0, rate_ff}) : dv_s_in[RW-1:0];
   end

   assign batch_in = (32'(batch_ff) > 32'(MAX_BATCH)) ? BW'(MAX_BATCH) : BW'(batch_ff);

   // saturate, then catch up to now
   always_comb begin
      if (sum_ff > W'({T{1'b1}})) begin
         nd_in = {T{1'b1}};
      end else begin
         nd_in = T'(sum_ff);
      end
      if (nd_in < now_ff) begin
         nd_in = now_ff;
      end
   end

   // profile memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_t[wr_addr_in] <= ptime_in;
         mem_r[wr_addr_in] <= req_data.point_rate;
      end
      t_rd_ff <= mem_t[idx_ff];
      r_rd_ff <= mem_r[idx_ff];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pacing_rate_ff <= '0;
         use_profile_ff <= 1'b0;
         batch_ff       <= prp_pkg::BATCH_RESET;
         count_ff       <= prp_pkg::COUNT_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            prp_pkg::REG_PACING_RATE:   pacing_rate_ff <= pwdata[RW-1:0];
            prp_pkg::REG_USE_PROFILE:   use_profile_ff <= pwdata[0];
            prp_pkg::REG_BATCH_SIZE:    batch_ff       <= pwdata[prp_pkg::BATCH_W-1:0];
            prp_pkg::REG_PROFILE_COUNT: count_ff       <= pwdata[prp_pkg::COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         prp_pkg::REG_PACING_RATE:   prdata = 32'(pacing_rate_ff);
         prp_pkg::REG_USE_PROFILE:   prdata = 32'(use_profile_ff);
         prp_pkg::REG_BATCH_SIZE:    prdata = 32'(batch_ff);
         prp_pkg::REG_PROFILE_COUNT: prdata = 32'(count_ff);
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         deadline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // S_OUT drives the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  now_ff      <= now_in;
                  res_go_ff   <= 1'b0;
                  res_rate_ff <= '0;
                  state_ff    <= S_OUT;
                  if (req_data.mode == prp_pkg::MODE_START) begin
                     start_ff    <= now_in;
                     deadline_ff <= now_in;
                  end else if (req_data.mode == prp_pkg::MODE_PACE) begin
                     if (pacing_rate_ff == '0 && !use_profile_ff) begin
                        res_go_ff <= 1'b1;
                     end else if (now_in >= deadline_ff) begin
                        if (use_profile_ff) begin
                           e_ff     <= now_in - start_ff;
                           idx_ff   <= '0;
                           last_ff  <= last_in;
                           state_ff <= S_FETCH;
                        end else begin
                           rate_ff  <= pacing_rate_ff;
                           state_ff <= S_PREP;
                        end
                     end
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (e_ff <= t_rd_ff) begin
                  if (idx_ff == '0) begin
                     rate_ff  <= r_rd_ff;
                     state_ff <= S_PREP;
                  end else begin
                     md_num_ff  <= e_ff - prev_t_ff;
                     md_div_ff  <= {1'b0, t_rd_ff - prev_t_ff} + (T+1)'(1);
                     md_neg_ff  <= r_rd_ff < prev_r_ff;
                     md_diff_ff <= (r_rd_ff >= prev_r_ff) ? r_rd_ff - prev_r_ff
                                                          : prev_r_ff - r_rd_ff;
                     md_r0_ff   <= prev_r_ff;
                     md_rem_ff  <= '0;
                     md_q_ff    <= '0;
                     md_cnt_ff  <= 5'(RW);
                     state_ff   <= S_MD;
                  end
               end else if (idx_ff == last_ff) begin
                  rate_ff  <= r_rd_ff;
                  state_ff <= S_PREP;
               end else begin
                  prev_t_ff <= t_rd_ff;
                  prev_r_ff <= r_rd_ff;
                  idx_ff    <= idx_ff + AW'(1);
                  state_ff  <= S_FETCH;
               end
            end
            S_MD: begin
               md_rem_ff  <= md_rem_in;
               md_q_ff    <= md_q_in;
               md_diff_ff <= {md_diff_ff[RW-2:0], 1'b0};
               md_cnt_ff  <= md_cnt_ff - 5'd1;
               if (md_cnt_ff == 5'd1) begin
                  rate_ff  <= md_neg_ff ? md_r0_ff - md_q_in : md_r0_ff + md_q_in;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               if (rate_ff == '0) begin
                  rate_ff <= RW'(1);
               end
               dv_num_ff <= NW'(batch_in) * NW'(prp_pkg::NS_PER_SEC);
               dv_rem_ff <= '0;
               dv_q_ff   <= '0;
               dv_cnt_ff <= DCW'(NW);
               state_ff  <= S_DIV;
            end
            S_DIV: begin
               dv_rem_ff <= dv_rem_in;
               dv_q_ff   <= {dv_q_ff[NW-2:0], dv_ge_in};
               dv_num_ff <= {dv_num_ff[NW-2:0], 1'b0};
               dv_cnt_ff <= dv_cnt_ff - DCW'(1);
               if (dv_cnt_ff == DCW'(1)) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               sum_ff   <= W'(deadline_ff) + W'(dv_q_ff);
               state_ff <= S_END;
            end
            S_END: begin
               deadline_ff <= nd_in;
               res_go_ff   <= 1'b1;
               res_rate_ff <= rate_ff;
               state_ff    <= S_OUT;
            end
            S_OUT: begin
               // hand the result to the output register once it is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.go            <= res_go_ff;
                  rsp_data_ff.deadline      <= prp_pkg::FIELD_TIME_W'(deadline_ff);
                  rsp_data_ff.applied_rate  <= res_rate_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PRP_ASSERT(a_load_keeps_dl, (req_xfer && req_data.mode == prp_pkg::MODE_LOAD) |=> $stable(deadline_ff), "load item moved the deadline")
   `PRP_ASSERT(a_nogo_norate, (rsp_valid_ff && !rsp_data_ff.go) |-> (rsp_data_ff.applied_rate == '0), "refused result carries a rate")
   `PRP_ASSERT(a_md_rem, (state_ff == S_MD) |-> ({1'b0, md_rem_ff} < md_div_ff), "interpolation remainder not below span")
   `PRP_ASSERT(a_dv_rem, (state_ff == S_DIV) |-> ((rate_ff != '0) && (dv_rem_ff < rate_ff)), "batch time remainder not below rate")
   `PRP_ASSERT_ALWAYS(a_stall_reset, $past(reset) |-> !req_stall, "input stalled right after reset")

endmodule

// ===== verif/tb_profile_rate_pacer.sv =====
// Self-checking testbench of profile_rate_pacer: directed and random items,
// with results checked against an in-bench pacing predictor.
// Depends on prp_pkg and the profile_rate_pacer RTL.
module tb_profile_rate_pacer;

   localparam longint unsigned TIME_MASK = 64'h0000_FFFF_FFFF_FFFF;
   localparam int DEPTH = prp_pkg::DEF_PROFILE_DEPTH;
   localparam int STALL_LIMIT = 20000;
   // mode code with no action
   localparam logic [1:0] MODE_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   prp_pkg::req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   prp_pkg::rsp_type rsp_data;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;

   profile_rate_pacer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // pacer state as predicted
   logic [47:0]     prof_time [DEPTH];
   logic [26:0]     prof_rate [DEPTH];
   longint unsigned start_ns, deadline_ns;
   logic [26:0]     fixed_rate;
   logic            use_prof;
   logic [6:0]      batch;
   logic [8:0]      prof_count;

   prp_pkg::rsp_type pending_q[$];
   int      errors = 0;
   int      send_idle = 0;
   int      stall_pct = 0;
   int      items_sent = 0;
   int      quiet_cycles = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL profile_rate_pacer");
         $finish;
      end
   end

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      prp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            report("unexpected transfer", rsp_data.deadline, 0);
         end else begin
            want = pending_q.pop_front();
            if (rsp_data.go !== want.go) report("go", rsp_data.go, want.go);
            if (rsp_data.deadline !== want.deadline)
               report("deadline", rsp_data.deadline, want.deadline);
            if (rsp_data.applied_rate !== want.applied_rate)
               report("applied_rate", rsp_data.applied_rate, want.applied_rate);
         end
      end
   end

   function automatic longint unsigned profile_rate_at(longint unsigned e);
      int              n;
      longint unsigned t0, r0, r1, num, span;
      logic [127:0]    prod;
      logic [127:0]    quo;
      n = prof_count;
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      if (e <= prof_time[0]) return prof_rate[0];
      for (int i = 1; i < n; i++) begin
         if (e <= prof_time[i]) begin
            t0 = prof_time[i-1];
            r0 = prof_rate[i-1];
            r1 = prof_rate[i];
            num = e - t0;
            span = prof_time[i] - t0;
            if (r1 >= r0) begin
               prod = 128'(num) * 128'(r1 - r0);
               quo = prod / (128'(span) + 128'd1);
               return r0 + quo[63:0];
            end
            prod = 128'(num) * 128'(r0 - r1);
            quo = prod / (128'(span) + 128'd1);
            return r0 - quo[63:0];
         end
      end
      return prof_rate[n-1];
   endfunction

   function automatic prp_pkg::rsp_type pace_predict(prp_pkg::req_type r);
      prp_pkg::rsp_type res;
      longint unsigned  now, rate, b, step, nd;
      res = '0;
      now = r.now_time;
      unique case (r.mode)
         prp_pkg::MODE_START: begin
            start_ns = now;
            deadline_ns = now;
         end
         prp_pkg::MODE_LOAD: begin
            prof_time[r.point_index] = r.point_time;
            prof_rate[r.point_index] = r.point_rate;
         end
         prp_pkg::MODE_PACE: begin
            if (fixed_rate == 0 && !use_prof) begin
               res.go = 1'b1;
            end else if (now >= deadline_ns) begin
               rate = use_prof ? profile_rate_at((now - start_ns) & TIME_MASK) : fixed_rate;
               if (rate < 1) rate = 1;
               b = (batch > prp_pkg::DEF_MAX_BATCH) ? prp_pkg::DEF_MAX_BATCH : batch;
               step = (b * prp_pkg::NS_PER_SEC) / rate;
               if (step > TIME_MASK - deadline_ns) nd = TIME_MASK;
               else nd = deadline_ns + step;
               if (nd < now) nd = now;
               deadline_ns = nd;
               res.go = 1'b1;
               res.applied_rate = rate[26:0];
            end
         end
         default: ;
      endcase
      res.deadline = deadline_ns[47:0];
      return res;
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[47:0];
   endfunction

   task automatic send(prp_pkg::req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_q.push_back(pace_predict(r));
      items_sent++;
      if ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic send_item(logic [1:0] mode, logic [7:0] idx, logic [47:0] pt,
                            logic [26:0] pr, logic [47:0] now);
      prp_pkg::req_type r;
      r.mode = mode;
      r.point_index = idx;
      r.point_time = pt;
      r.point_rate = pr;
      r.now_time = now;
      send(r);
   endtask

   task automatic pace_at(longint unsigned now);
      send_item(prp_pkg::MODE_PACE, 8'($urandom), rand48(), 27'($urandom), now[47:0]);
   endtask

   // drop valid and drain before touching registers
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      unique case (idx)
         prp_pkg::REG_PACING_RATE:   fixed_rate = value[26:0];
         prp_pkg::REG_USE_PROFILE:   use_prof = value[0];
         prp_pkg::REG_BATCH_SIZE:    batch = value[6:0];
         prp_pkg::REG_PROFILE_COUNT: prof_count = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_unpaced();
      pace_at(0);
      pace_at(TIME_MASK);
      send_item(MODE_NONE, 8'hFF, 48'hFFFF_FFFF_FFFF, 27'h7FF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_item(prp_pkg::MODE_START, 8'h00, 48'h0, 27'h0, 48'd500);
   endtask

   task automatic test_fixed_rate();
      settle();
      csr_write(prp_pkg::REG_PACING_RATE, 100_000_000);
      csr_write(prp_pkg::REG_BATCH_SIZE, 64);
      send_item(prp_pkg::MODE_START, 8'd0, 48'd0, 27'd0, 48'd1000);
      pace_at(1000);
      pace_at(1500);
      pace_at(1640);
      pace_at(5_000_000);
      settle();
      csr_write(prp_pkg::REG_BATCH_SIZE, 0);
      pace_at(5_000_000);
      settle();
      csr_write(prp_pkg::REG_BATCH_SIZE, 127);
      csr_write(prp_pkg::REG_PACING_RATE, 32'h07FF_FFFF);
      pace_at(6_000_000);
      // saturate the deadline near the top of the time range
      settle();
      csr_write(prp_pkg::REG_PACING_RATE, 1);
      send_item(prp_pkg::MODE_START, 8'd0, 48'd0, 27'd0, 48'hFFFF_FFFF_FC00);
      pace_at(64'hFFFF_FFFF_FC00);
      pace_at(64'hFFFF_FFFF_FFFF);
   endtask

   task automatic test_profile();
      send_idle = 60;
      for (int i = 0; i < DEPTH; i++)
         send_item(prp_pkg::MODE_LOAD, 8'(i), 48'(i * 1000),
                   27'($urandom_range(100_000_000)), 48'd0);
      send_item(prp_pkg::MODE_LOAD, 8'd0, 48'd0, 27'd1_000_000, 48'd0);
      send_item(prp_pkg::MODE_LOAD, 8'd1, 48'd1000, 27'd0, 48'd0);
      send_item(prp_pkg::MODE_LOAD, 8'd2, 48'd2000, 27'd100_000_000, 48'd0);
      send_item(prp_pkg::MODE_LOAD, 8'd3, 48'd3000, 27'h7FF_FFFF, 48'd0);
      send_idle = 0;
      settle();
      csr_write(prp_pkg::REG_USE_PROFILE, 1);
      csr_write(prp_pkg::REG_PROFILE_COUNT, 4);
      csr_write(prp_pkg::REG_BATCH_SIZE, 0);
      // batch zero keeps the deadline on now, so elapsed time walks freely
      send_item(prp_pkg::MODE_START, 8'd0, 48'd0, 27'd0, 48'd0);
      pace_at(0);
      pace_at(500);
      pace_at(1000);
      pace_at(1500);
      pace_at(2700);
      pace_at(10_000);
      settle();
      csr_write(prp_pkg::REG_PROFILE_COUNT, 0);
      pace_at(20_000);
      settle();
      csr_write(prp_pkg::REG_PROFILE_COUNT, 300);
      csr_write(prp_pkg::REG_BATCH_SIZE, 1);
      pace_at(300_000);
   endtask

   task automatic random_config();
      int      sel;
      logic [31:0] v;
      sel = $urandom_range(9);
      v = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 100_000_000 :
          (sel == 3) ? 32'h07FF_FFFF : (sel < 7) ? $urandom_range(100_000_000)
          : $urandom_range(100_000, 1);
      csr_write(prp_pkg::REG_PACING_RATE, v);
      csr_write(prp_pkg::REG_USE_PROFILE, $urandom_range(1));
      sel = $urandom_range(9);
      v = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(127, 65) : $urandom_range(64, 1);
      csr_write(prp_pkg::REG_BATCH_SIZE, v);
      sel = $urandom_range(19);
      v = (sel == 0) ? 0 : (sel == 1) ? 256 : (sel == 2) ? $urandom_range(511, 257) :
          (sel < 5) ? $urandom_range(255, 1) : $urandom_range(16, 1);
      csr_write(prp_pkg::REG_PROFILE_COUNT, v);
   endtask

   task automatic random_sequence();
      int              spacing, sel;
      longint unsigned now, base;
      settle();
      random_config();
      if (use_prof && prof_count <= 16 && prof_count > 0 && $urandom_range(1)) begin
         spacing = $urandom_range(5000, 1);
         for (int i = 0; i < prof_count; i++)
            send_item(prp_pkg::MODE_LOAD, 8'(i), 48'(i * spacing),
                      27'($urandom_range(100_000_000)), rand48());
      end
      base = ($urandom_range(9) < 7) ? $urandom_range(1_000_000) : rand48();
      send_item(prp_pkg::MODE_START, 8'($urandom), rand48(), 27'($urandom), base[47:0]);
      repeat ($urandom_range(20, 5)) begin
         sel = $urandom_range(99);
         if (sel < 80) begin
            sel = $urandom_range(99);
            if (sel < 40) now = deadline_ns + $urandom_range(50);
            else if (sel < 60) now = deadline_ns - $urandom_range(1000, 1);
            else if (sel < 85) now = deadline_ns + $urandom_range(1 << 20);
            else if (sel < 95) now = start_ns + $urandom_range(10_000);
            else now = rand48();
            pace_at(now & TIME_MASK);
         end else if (sel < 88) begin
            send_item(prp_pkg::MODE_LOAD, 8'($urandom), rand48(), 27'($urandom), rand48());
         end else if (sel < 95) begin
            send_item(MODE_NONE, 8'($urandom), rand48(), 27'($urandom), rand48());
         end else begin
            send_item(prp_pkg::MODE_START, 8'($urandom), rand48(), 27'($urandom),
                      48'(deadline_ns + $urandom_range(5000)));
         end
      end
   endtask

   task automatic test_random();
      int target;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 7) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 60 : 7) : 0;
         target = items_sent + 390;
         while (items_sent < target) random_sequence();
      end
      send_idle = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      start_ns = 0;
      deadline_ns = 0;
      fixed_rate = '0;
      use_prof = 1'b0;
      batch = prp_pkg::BATCH_RESET;
      prof_count = prp_pkg::COUNT_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         prof_time[i] = '0;
         prof_rate[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unpaced();
      test_fixed_rate();
      test_profile();
      test_random();

      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("PASS profile_rate_pacer");
      else $display("FAIL profile_rate_pacer");
      $finish;
   end

endmodule
